// ===== rtl/ppkt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pressure pad key tracker package
// Shared widths, constants, codes and structures of the key tracker.
// ----------------------------------------------------------------------------
package ppkt_pkg;

    localparam int unsigned FORCE_W     = 16;
    localparam int unsigned TIME_W      = 32;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned DIV_STEPS   = FORCE_W;
    localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [FORCE_W-1:0] FORCE_MAX        = 16'hFFFF;
    localparam logic [FORCE_W-1:0] CURVE_FULL_SCALE = 16'hFFFF;
    localparam logic [FORCE_W-1:0] HOLD_TIME_RST    = 16'd400;
    localparam logic [FORCE_W-1:0] CHANGE_STEP_RST  = 16'd256;

    typedef enum logic [3:0] {
        KS_INVALID     = 4'd0,
        KS_IDLE        = 4'd1,
        KS_DEBOUNCE    = 4'd2,
        KS_PRESSED     = 4'd3,
        KS_ACTIVATED   = 4'd4,
        KS_HOLD        = 4'd5,
        KS_AFTERTOUCH  = 4'd6,
        KS_RELDEBOUNCE = 4'd7,
        KS_RELEASED    = 4'd8
    } key_state_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_THRESHOLD     = 3'd0,
        CFG_HIGH_THRESHOLD    = 3'd1,
        CFG_ACTIVATION_OFFSET = 3'd2,
        CFG_DEBOUNCE_MS       = 3'd3,
        CFG_CURVE_ENABLE      = 3'd4,
        CFG_HOLD_TIME_MS      = 3'd5,
        CFG_CHANGE_STEP       = 3'd6
    } cfg_index_t;

    typedef enum logic {
        MODE_SAMPLE   = 1'b0,
        MODE_SUPPRESS = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_FINISH
    } back_state_t;

    typedef struct packed {
        logic [FORCE_W-1:0] low_threshold;
        logic [FORCE_W-1:0] high_threshold;
        logic [FORCE_W-1:0] activation_offset;
        logic [FORCE_W-1:0] debounce_ms;
        logic               curve_enable;
        logic [FORCE_W-1:0] hold_time_ms;
        logic [FORCE_W-1:0] change_step;
    } cfg_t;

    // Item as classified by the front end.
    typedef struct packed {
        logic               mode;
        logic [FORCE_W-1:0] force_sample;
        logic [TIME_W-1:0]  time_ms;
        logic               above_press;
        logic               at_or_below_low;
        logic               below_low;
        logic               at_or_above_high;
        logic               needs_div;
    } item_t;

endpackage

// ===== rtl/ppkt_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key tracker channels
// Valid/ready channels for force items and for tracker results.
// ----------------------------------------------------------------------------
interface ppkt_in_if;
    logic                           valid;
    logic                           ready;
    logic                           mode;
    logic [ppkt_pkg::FORCE_W-1:0]   force_sample;
    logic [ppkt_pkg::TIME_W-1:0]    time_ms;

    modport source (output valid, output mode, output force_sample, output time_ms,
                    input ready);
    modport sink (input valid, input mode, input force_sample, input time_ms,
                  output ready);
endinterface

interface ppkt_out_if;
    logic                           valid;
    logic                           ready;
    logic                           event_res;
    logic [3:0]                     key_state;
    logic [ppkt_pkg::FORCE_W-1:0]   pressure;

    modport source (output valid, output event_res, output key_state, output pressure,
                    input ready);
    modport sink (input valid, input event_res, input key_state, input pressure,
                  output ready);
endinterface

// ===== rtl/ppkt_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key tracker front end
// Registers each incoming item and classifies its force against thresholds.
// ----------------------------------------------------------------------------
module ppkt_front (
    input  logic                clk,
    input  logic                rst_n,
    input  ppkt_pkg::cfg_t      cfg,
    ppkt_in_if.sink             in_ch,
    output logic                push_valid,
    input  logic                push_ready,
    output ppkt_pkg::item_t     push_item
);

    logic                               valid_reg;
    logic                               mode_reg;
    logic [ppkt_pkg::FORCE_W-1:0]       force_reg;
    logic [ppkt_pkg::TIME_W-1:0]        time_reg;
    logic [ppkt_pkg::FORCE_W:0]         press_level;
    logic                               take;

    assign in_ch.ready = !valid_reg || push_ready;
    assign take        = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            mode_reg  <= in_ch.mode;
            force_reg <= in_ch.force_sample;
            time_reg  <= in_ch.time_ms;
        end
    end

    // The press level is one bit wider so that it never wraps.
    assign press_level = {1'b0, cfg.low_threshold} + {1'b0, cfg.activation_offset};

    always_comb
    begin
        push_item.mode             = mode_reg;
        push_item.force_sample     = force_reg;
        push_item.time_ms          = time_reg;
        push_item.above_press      = {1'b0, force_reg} > press_level;
        push_item.at_or_below_low  = force_reg <= cfg.low_threshold;
        push_item.below_low        = force_reg < cfg.low_threshold;
        push_item.at_or_above_high = force_reg >= cfg.high_threshold;
        push_item.needs_div        = cfg.curve_enable
                                     && !(force_reg < cfg.low_threshold)
                                     && !(force_reg >= cfg.high_threshold);
    end

    assign push_valid = valid_reg;

endmodule

// ===== rtl/ppkt_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key tracker item queue
// Short first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module ppkt_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  ppkt_pkg::item_t     push_item,
    output logic                pop_valid,
    input  logic                pop_ready,
    output ppkt_pkg::item_t     pop_item
);

    ppkt_pkg::item_t                    store_reg [ppkt_pkg::QUEUE_DEPTH];
    logic [ppkt_pkg::QPTR_W-1:0]        head_reg;
    logic [ppkt_pkg::QPTR_W-1:0]        head_next;
    logic [ppkt_pkg::QPTR_W-1:0]        tail_reg;
    logic [ppkt_pkg::QPTR_W-1:0]        tail_next;
    logic [ppkt_pkg::QPTR_W:0]          count_reg;
    logic [ppkt_pkg::QPTR_W:0]          count_next;
    logic                               do_push;
    logic                               do_pop;

    assign push_ready = count_reg != (ppkt_pkg::QPTR_W + 1)'(ppkt_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = store_reg[head_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (do_push)
        begin
            tail_next = (tail_reg == ppkt_pkg::QPTR_W'(ppkt_pkg::QUEUE_DEPTH - 1))
                        ? '0 : tail_reg + 1'b1;
        end
        if (do_pop)
        begin
            head_next = (head_reg == ppkt_pkg::QPTR_W'(ppkt_pkg::QUEUE_DEPTH - 1))
                        ? '0 : head_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[tail_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/ppkt_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key tracker back end
// Runs the force curve divider when an item needs it, and the press state machine for each item.
// ----------------------------------------------------------------------------
module ppkt_back (
    input  logic                clk,
    input  logic                rst_n,
    input  ppkt_pkg::cfg_t      cfg,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  ppkt_pkg::item_t     pop_item,
    ppkt_out_if.source          out_ch
);

    localparam int unsigned FW = ppkt_pkg::FORCE_W;
    localparam int unsigned TW = ppkt_pkg::TIME_W;

    ppkt_pkg::back_state_t              bk_reg, bk_next;
    ppkt_pkg::item_t                    item_reg, item_next;
    logic [FW-1:0]                      dvs_reg, dvs_next;
    logic [FW-1:0]                      rem_reg, rem_next;
    logic [FW-1:0]                      qn_reg, qn_next;
    logic [ppkt_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;

    ppkt_pkg::key_state_t               press_state_reg, press_state_next;
    logic [TW-1:0]                      last_event_time_reg, last_event_time_next;
    logic [FW-1:0]                      last_pressure_reg, last_pressure_next;
    logic                               hold_seen_reg, hold_seen_next;
    logic                               muted_reg, muted_next;

    logic                               out_valid_reg, out_valid_next;
    logic                               out_event_reg, out_event_next;
    ppkt_pkg::key_state_t               out_state_reg, out_state_next;
    logic [FW-1:0]                      out_pressure_reg, out_pressure_next;

    logic [FW-1:0]                      diff_in;
    logic [2*FW-1:0]                    numer;
    logic [FW:0]                        trial;
    logic                               trial_ge;
    logic [FW-1:0]                      curve_val;
    logic [FW-1:0]                      abs_diff;
    logic [TW-1:0]                      since_event;
    logic [TW-1:0]                      since_renew;
    logic                               ev;
    logic                               go_on;
    ppkt_pkg::key_state_t               cur;

    // Numerator of the curve: (force - low) * full scale, done as a shift and subtract.
    assign diff_in = pop_item.force_sample - cfg.low_threshold;
    assign numer   = {diff_in, {FW{1'b0}}} - {{FW{1'b0}}, diff_in};

    // One restoring division step per cycle; quotient bits replace numerator bits.
    assign trial    = {rem_reg, qn_reg[FW-1]};
    assign trial_ge = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        if (!cfg.curve_enable)
        begin
            curve_val = item_reg.force_sample;
        end
        else if (item_reg.below_low)
        begin
            curve_val = '0;
        end
        else if (item_reg.at_or_above_high)
        begin
            curve_val = ppkt_pkg::CURVE_FULL_SCALE;
        end
        else
        begin
            curve_val = qn_reg;
        end
    end

    assign abs_diff    = (curve_val > last_pressure_reg) ? curve_val - last_pressure_reg
                                                         : last_pressure_reg - curve_val;
    assign since_event = item_reg.time_ms - last_event_time_reg;

    always_comb
    begin
        bk_next              = bk_reg;
        item_next            = item_reg;
        dvs_next             = dvs_reg;
        rem_next             = rem_reg;
        qn_next              = qn_reg;
        cnt_next             = cnt_reg;
        press_state_next     = press_state_reg;
        last_event_time_next = last_event_time_reg;
        last_pressure_next   = last_pressure_reg;
        hold_seen_next       = hold_seen_reg;
        muted_next           = muted_reg;
        out_valid_next       = out_valid_reg && !out_ch.ready;
        out_event_next       = out_event_reg;
        out_state_next       = out_state_reg;
        out_pressure_next    = out_pressure_reg;
        pop_ready            = 1'b0;
        ev                   = 1'b0;
        go_on                = 1'b0;
        cur                  = press_state_reg;
        since_renew          = '0;

        unique case (bk_reg)
            ppkt_pkg::BK_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    item_next = pop_item;
                    dvs_next  = cfg.high_threshold - cfg.low_threshold;
                    rem_next  = numer[2*FW-1:FW];
                    qn_next   = numer[FW-1:0];
                    cnt_next  = ppkt_pkg::DIV_CNT_W'(ppkt_pkg::DIV_STEPS - 1);
                    bk_next   = (pop_item.mode == ppkt_pkg::MODE_SAMPLE && pop_item.needs_div)
                                ? ppkt_pkg::BK_DIV : ppkt_pkg::BK_FINISH;
                end
            end

            ppkt_pkg::BK_DIV:
            begin
                rem_next = trial_ge ? FW'(trial - {1'b0, dvs_reg}) : trial[FW-1:0];
                qn_next  = {qn_reg[FW-2:0], trial_ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    bk_next = ppkt_pkg::BK_FINISH;
                end
            end

            ppkt_pkg::BK_FINISH:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    bk_next = ppkt_pkg::BK_IDLE;
                    if (item_reg.mode == ppkt_pkg::MODE_SUPPRESS)
                    begin
                        if (press_state_reg == ppkt_pkg::KS_PRESSED
                            || press_state_reg == ppkt_pkg::KS_ACTIVATED
                            || press_state_reg == ppkt_pkg::KS_HOLD
                            || press_state_reg == ppkt_pkg::KS_AFTERTOUCH)
                        begin
                            muted_next = 1'b1;
                        end
                    end
                    else
                    begin
                        // A fresh or finished press starts over from idle.
                        if (press_state_reg == ppkt_pkg::KS_INVALID
                            || press_state_reg == ppkt_pkg::KS_RELEASED)
                        begin
                            press_state_next     = ppkt_pkg::KS_IDLE;
                            last_event_time_next = item_reg.time_ms;
                            muted_next           = 1'b0;
                            hold_seen_next       = 1'b0;
                            cur                  = ppkt_pkg::KS_IDLE;
                        end

                        unique case (cur)
                            ppkt_pkg::KS_IDLE:
                            begin
                                if (item_reg.above_press)
                                begin
                                    last_event_time_next = item_reg.time_ms;
                                    if (cfg.debounce_ms != '0)
                                    begin
                                        press_state_next = ppkt_pkg::KS_DEBOUNCE;
                                    end
                                    else
                                    begin
                                        press_state_next   = ppkt_pkg::KS_PRESSED;
                                        last_pressure_next = curve_val;
                                        ev                 = !muted_next;
                                    end
                                end
                            end

                            ppkt_pkg::KS_DEBOUNCE:
                            begin
                                if (!item_reg.above_press)
                                begin
                                    press_state_next     = ppkt_pkg::KS_IDLE;
                                    last_event_time_next = item_reg.time_ms;
                                end
                                else if (since_event > {{(TW-FW){1'b0}}, cfg.debounce_ms})
                                begin
                                    press_state_next     = ppkt_pkg::KS_PRESSED;
                                    last_event_time_next = item_reg.time_ms;
                                    last_pressure_next   = curve_val;
                                    ev                   = !muted_next;
                                end
                            end

                            ppkt_pkg::KS_RELDEBOUNCE:
                            begin
                                if (item_reg.at_or_below_low)
                                begin
                                    press_state_next     = ppkt_pkg::KS_RELEASED;
                                    last_event_time_next = item_reg.time_ms;
                                    ev                   = !muted_next;
                                end
                                else
                                begin
                                    go_on = 1'b1;
                                    if (since_event > {{(TW-FW){1'b0}}, cfg.debounce_ms})
                                    begin
                                        last_event_time_next = item_reg.time_ms;
                                    end
                                end
                            end

                            ppkt_pkg::KS_PRESSED, ppkt_pkg::KS_ACTIVATED,
                            ppkt_pkg::KS_HOLD, ppkt_pkg::KS_AFTERTOUCH:
                            begin
                                go_on = 1'b1;
                            end

                            default:
                            begin
                                go_on = 1'b0;
                            end
                        endcase

                        if (go_on)
                        begin
                            press_state_next = ppkt_pkg::KS_ACTIVATED;
                            since_renew      = item_reg.time_ms - last_event_time_next;
                            if (item_reg.at_or_below_low)
                            begin
                                last_event_time_next = item_reg.time_ms;
                                if (cfg.debounce_ms != '0)
                                begin
                                    press_state_next = ppkt_pkg::KS_RELDEBOUNCE;
                                end
                                else
                                begin
                                    press_state_next = ppkt_pkg::KS_RELEASED;
                                    ev               = !muted_next;
                                end
                            end
                            else if (since_renew > {{(TW-FW){1'b0}}, cfg.hold_time_ms}
                                     && !hold_seen_reg)
                            begin
                                press_state_next   = ppkt_pkg::KS_HOLD;
                                last_pressure_next = curve_val;
                                hold_seen_next     = 1'b1;
                                ev                 = !muted_next;
                            end
                            else if (abs_diff > cfg.change_step
                                     || (curve_val != last_pressure_reg
                                         && curve_val == ppkt_pkg::CURVE_FULL_SCALE))
                            begin
                                press_state_next   = ppkt_pkg::KS_AFTERTOUCH;
                                last_pressure_next = curve_val;
                                ev                 = !muted_next;
                            end
                        end
                    end

                    out_valid_next    = 1'b1;
                    out_event_next    = ev;
                    out_state_next    = press_state_next;
                    out_pressure_next = last_pressure_next;
                end
            end

            default:
            begin
                bk_next = ppkt_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bk_reg              <= ppkt_pkg::BK_IDLE;
            press_state_reg     <= ppkt_pkg::KS_INVALID;
            last_event_time_reg <= '0;
            last_pressure_reg   <= '0;
            hold_seen_reg       <= 1'b0;
            muted_reg           <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            bk_reg              <= bk_next;
            press_state_reg     <= press_state_next;
            last_event_time_reg <= last_event_time_next;
            last_pressure_reg   <= last_pressure_next;
            hold_seen_reg       <= hold_seen_next;
            muted_reg           <= muted_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg         <= item_next;
        dvs_reg          <= dvs_next;
        rem_reg          <= rem_next;
        qn_reg           <= qn_next;
        cnt_reg          <= cnt_next;
        out_event_reg    <= out_event_next;
        out_state_reg    <= out_state_next;
        out_pressure_reg <= out_pressure_next;
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.event_res = out_event_reg;
    assign out_ch.key_state = out_state_reg;
    assign out_ch.pressure  = out_pressure_reg;

endmodule

// ===== rtl/pressure_pad_key_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pressure pad key tracker
// Follows one pressure-sensitive key through debounce, hold and aftertouch.
// ----------------------------------------------------------------------------
//  Port        Direction  Carries
//  in_ch       in         mode, force_sample, time_ms (valid/ready)
//  out_ch      out        event_res, key_state, pressure (valid/ready)
//  cfg_*       in         register index and 16-bit write data
//
//  An item passes through the front register and the queue, then the back
//  end, which runs its 16-step serial divider when the force curve needs it.
//  Reset clears the press state and restores the register defaults.
//  A stalled output holds its result; the queue keeps taking items until full.
// ----------------------------------------------------------------------------
module pressure_pad_key_tracker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [ppkt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ppkt_pkg::CFG_DATA_W-1:0]     cfg_data,
    ppkt_in_if.sink                             in_ch,
    ppkt_out_if.source                          out_ch
);

    ppkt_pkg::cfg_t     cfg_reg;
    logic               push_valid;
    logic               push_ready;
    ppkt_pkg::item_t    push_item;
    logic               pop_valid;
    logic               pop_ready;
    ppkt_pkg::item_t    pop_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_threshold     <= '0;
            cfg_reg.high_threshold    <= ppkt_pkg::FORCE_MAX;
            cfg_reg.activation_offset <= '0;
            cfg_reg.debounce_ms       <= '0;
            cfg_reg.curve_enable      <= 1'b0;
            cfg_reg.hold_time_ms      <= ppkt_pkg::HOLD_TIME_RST;
            cfg_reg.change_step       <= ppkt_pkg::CHANGE_STEP_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ppkt_pkg::CFG_LOW_THRESHOLD:     cfg_reg.low_threshold     <= cfg_data;
                ppkt_pkg::CFG_HIGH_THRESHOLD:    cfg_reg.high_threshold    <= cfg_data;
                ppkt_pkg::CFG_ACTIVATION_OFFSET: cfg_reg.activation_offset <= cfg_data;
                ppkt_pkg::CFG_DEBOUNCE_MS:       cfg_reg.debounce_ms       <= cfg_data;
                ppkt_pkg::CFG_CURVE_ENABLE:      cfg_reg.curve_enable      <= cfg_data[0];
                ppkt_pkg::CFG_HOLD_TIME_MS:      cfg_reg.hold_time_ms      <= cfg_data;
                ppkt_pkg::CFG_CHANGE_STEP:       cfg_reg.change_step       <= cfg_data;
                default:                         cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    ppkt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_ch      (in_ch),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    ppkt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    ppkt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item),
        .out_ch     (out_ch)
    );

endmodule

// ===== tb/sv/ppkt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key tracker result checker
// Watches the configuration port and both channels. It keeps its own copy of
// the press machine, predicts one report per accepted item, and compares
// every report that leaves the block with the oldest prediction.
// ----------------------------------------------------------------------------
module ppkt_checker
    import ppkt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    ppkt_in_if                     in_ch,
    ppkt_out_if                    out_ch,
    output int unsigned            mismatches,
    output int unsigned            pending,
    output int unsigned            reports_checked,
    output int unsigned            key_events,
    output logic [8:0]             states_seen
);

    typedef struct packed {
        logic               ev;
        key_state_t         st;
        logic [FORCE_W-1:0] p;
    } key_report_t;

    localparam cfg_t CFG_DEFAULTS = '{
        low_threshold:     16'd0,
        high_threshold:    FORCE_MAX,
        activation_offset: 16'd0,
        debounce_ms:       16'd0,
        curve_enable:      1'b0,
        hold_time_ms:      HOLD_TIME_RST,
        change_step:       CHANGE_STEP_RST
    };

    cfg_t               regs;
    key_state_t         key_st;
    logic [TIME_W-1:0]  event_stamp;
    logic [FORCE_W-1:0] held_pressure;
    logic               hold_fired;
    logic               muted;

    key_report_t        expected_reports[$];
    int unsigned        n_bad;
    int unsigned        n_checked;
    int unsigned        n_events;
    logic [8:0]         seen;

    // Linear force curve between the two thresholds, clamped at both ends.
    function automatic logic [FORCE_W-1:0] shape_force(input logic [FORCE_W-1:0] f);
        logic [31:0] scaled;
        if (!regs.curve_enable)
            return f;
        if (f < regs.low_threshold)
            return 16'h0000;
        if (f >= regs.high_threshold)
            return CURVE_FULL_SCALE;
        scaled = (32'(f) - 32'(regs.low_threshold)) * 32'(CURVE_FULL_SCALE);
        return 16'(scaled / (32'(regs.high_threshold) - 32'(regs.low_threshold)));
    endfunction

    // Advances the press machine by one force sample; returns the event flag.
    function automatic logic track_sample(input logic [FORCE_W-1:0] f,
                                          input logic [TIME_W-1:0] now_ms);
        logic [16:0]        press_level;
        logic [TIME_W-1:0]  elapsed;
        logic [FORCE_W-1:0] v;
        logic [FORCE_W-1:0] diff;
        press_level = 17'(regs.low_threshold) + 17'(regs.activation_offset);
        if (key_st == KS_INVALID || key_st >= KS_RELEASED)
        begin
            key_st      = KS_IDLE;
            event_stamp = now_ms;
            muted       = 1'b0;
            hold_fired  = 1'b0;
        end
        elapsed = now_ms - event_stamp;
        case (key_st)
            KS_IDLE:
            begin
                if (17'(f) > press_level)
                begin
                    event_stamp = now_ms;
                    if (regs.debounce_ms != 16'd0)
                    begin
                        key_st = KS_DEBOUNCE;
                        return 1'b0;
                    end
                    key_st        = KS_PRESSED;
                    held_pressure = shape_force(f);
                    return !muted;
                end
                return 1'b0;
            end
            KS_DEBOUNCE:
            begin
                if (17'(f) <= press_level)
                begin
                    key_st      = KS_IDLE;
                    event_stamp = now_ms;
                    return 1'b0;
                end
                if (elapsed > 32'(regs.debounce_ms))
                begin
                    key_st        = KS_PRESSED;
                    event_stamp   = now_ms;
                    held_pressure = shape_force(f);
                    return !muted;
                end
                return 1'b0;
            end
            KS_RELDEBOUNCE:
            begin
                if (f <= regs.low_threshold)
                begin
                    key_st      = KS_RELEASED;
                    event_stamp = now_ms;
                    return !muted;
                end
                // A bounce back above the low threshold resumes the press.
                if (elapsed > 32'(regs.debounce_ms))
                    event_stamp = now_ms;
            end
            default: ;
        endcase

        key_st = KS_ACTIVATED;
        if (f <= regs.low_threshold)
        begin
            event_stamp = now_ms;
            if (regs.debounce_ms != 16'd0)
            begin
                key_st = KS_RELDEBOUNCE;
                return 1'b0;
            end
            key_st = KS_RELEASED;
            return !muted;
        end
        v       = shape_force(f);
        diff    = (v > held_pressure) ? v - held_pressure : held_pressure - v;
        elapsed = now_ms - event_stamp;
        if (elapsed > 32'(regs.hold_time_ms) && !hold_fired)
        begin
            key_st        = KS_HOLD;
            held_pressure = v;
            hold_fired    = 1'b1;
            return !muted;
        end
        if (diff > regs.change_step || (v != held_pressure && v == CURVE_FULL_SCALE))
        begin
            key_st        = KS_AFTERTOUCH;
            held_pressure = v;
            return !muted;
        end
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        key_report_t got;
        key_report_t want;
        logic        ev;
        if (!rst_n)
        begin
            regs          = CFG_DEFAULTS;
            key_st        = KS_INVALID;
            event_stamp   = '0;
            held_pressure = '0;
            hold_fired    = 1'b0;
            muted         = 1'b0;
            expected_reports.delete();
            n_bad         = 0;
            n_checked     = 0;
            n_events      = 0;
            seen          = '0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got = '{out_ch.event_res, key_state_t'(out_ch.key_state), out_ch.pressure};
                if (expected_reports.size() == 0)
                begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display({"%t: report with nothing outstanding: ",
                                  "event %0d state %0d pressure %0d"},
                                 $realtime, got.ev, got.st, got.p);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    n_checked++;
                    if (want.ev)
                        n_events++;
                    seen[want.st] = 1'b1;
                    if (got !== want)
                    begin
                        n_bad++;
                        if (n_bad <= 10)
                            $display({"%t: report %0d wrong: expected event %0d state %0d ",
                                      "pressure %0d, got event %0d state %0d pressure %0d"},
                                     $realtime, n_checked, want.ev, want.st, want.p,
                                     got.ev, got.st, got.p);
                    end
                end
            end

            if (cfg_write)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_LOW_THRESHOLD:     regs.low_threshold     = cfg_data;
                    CFG_HIGH_THRESHOLD:    regs.high_threshold    = cfg_data;
                    CFG_ACTIVATION_OFFSET: regs.activation_offset = cfg_data;
                    CFG_DEBOUNCE_MS:       regs.debounce_ms       = cfg_data;
                    CFG_CURVE_ENABLE:      regs.curve_enable      = cfg_data[0];
                    CFG_HOLD_TIME_MS:      regs.hold_time_ms      = cfg_data;
                    CFG_CHANGE_STEP:       regs.change_step       = cfg_data;
                    default: ;
                endcase
            end

            if (in_ch.valid && in_ch.ready)
            begin
                ev = 1'b0;
                if (in_ch.mode == MODE_SUPPRESS)
                begin
                    if (key_st inside {KS_PRESSED, KS_ACTIVATED, KS_HOLD, KS_AFTERTOUCH})
                        muted = 1'b1;
                end
                else
                    ev = track_sample(in_ch.force_sample, in_ch.time_ms);
                expected_reports.push_back(key_report_t'{ev, key_st, held_pressure});
            end
        end
        mismatches      <= n_bad;
        pending         <= expected_reports.size();
        reports_checked <= n_checked;
        key_events      <= n_events;
        states_seen     <= seen;
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key tracker testbench
// Drives force samples and suppress commands through a run of register
// settings, with bursty input, a stalling receiver and one long hold-off,
// and gives the verdict from the checker's mismatch and outstanding report counts.
// ----------------------------------------------------------------------------
module tb_top;
    import ppkt_pkg::*;

    typedef enum int {
        STEP_SHORT,
        STEP_DEBOUNCE,
        STEP_HOLD,
        STEP_ANY
    } step_kind_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    cfg_index_t             cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    ppkt_in_if  in_ch ();
    ppkt_out_if out_ch ();

    int unsigned            mismatches;
    int unsigned            pending;
    int unsigned            reports_checked;
    int unsigned            key_events;
    logic [8:0]             states_seen;

    cfg_t                   active_cfg;
    logic [TIME_W-1:0]      stamp_ms;
    int unsigned            items_sent;
    int unsigned            suppress_sent;
    int unsigned            burst_left;
    int unsigned            settings_used;
    bit                     long_stall_done;

    pressure_pad_key_tracker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    ppkt_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_ch           (in_ch),
        .out_ch          (out_ch),
        .mismatches      (mismatches),
        .pending         (pending),
        .reports_checked (reports_checked),
        .key_events      (key_events),
        .states_seen     (states_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("Timed out with %0d reports outstanding.", pending);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic cfg_t make_cfg(input logic [15:0] lo, input logic [15:0] hi,
                                      input logic [15:0] offset, input logic [15:0] deb,
                                      input logic curve, input logic [15:0] hold,
                                      input logic [15:0] step);
        cfg_t c;
        c.low_threshold     = lo;
        c.high_threshold    = hi;
        c.activation_offset = offset;
        c.debounce_ms       = deb;
        c.curve_enable      = curve;
        c.hold_time_ms      = hold;
        c.change_step       = step;
        return c;
    endfunction

    function automatic cfg_t random_cfg();
        cfg_t c;
        c.low_threshold     = 16'($urandom_range(30000, 0));
        c.high_threshold    = ($urandom_range(3, 0) == 0) ? 16'($urandom)
                              : c.low_threshold + 16'($urandom_range(30000, 1));
        c.activation_offset = 16'($urandom_range(2000, 0));
        c.debounce_ms       = 16'($urandom_range(10, 0));
        c.curve_enable      = 1'($urandom_range(1, 0));
        c.hold_time_ms      = 16'($urandom_range(120, 0));
        c.change_step       = 16'($urandom_range(3000, 0));
        return c;
    endfunction

    function automatic logic [16:0] press_level();
        return 17'(active_cfg.low_threshold) + 17'(active_cfg.activation_offset);
    endfunction

    // Force that starts a press from idle.
    function automatic logic [15:0] pick_press();
        logic [16:0] level;
        level = press_level();
        if (level >= 17'h0FFFF)
            return 16'($urandom);
        case ($urandom_range(3, 0))
            0:       return 16'(level + 17'd1);
            1:       return FORCE_MAX;
            default: return 16'($urandom_range(65535, level + 17'd1));
        endcase
    endfunction

    // Force that leaves an idle key alone.
    function automatic logic [15:0] pick_quiet();
        logic [16:0] level;
        level = press_level();
        if (level >= 17'h0FFFF)
            return 16'($urandom);
        case ($urandom_range(3, 0))
            0:       return 16'(level);
            1:       return 16'h0000;
            default: return 16'($urandom_range(level, 0));
        endcase
    endfunction

    // Force that keeps a pressed key down, unless a high threshold at or below the low one is picked.
    function automatic logic [15:0] pick_held();
        if (active_cfg.low_threshold == FORCE_MAX)
            return FORCE_MAX;
        case ($urandom_range(5, 0))
            0:       return FORCE_MAX;
            1:       return active_cfg.low_threshold + 16'd1;
            2:       return active_cfg.high_threshold;
            default: return 16'($urandom_range(65535, active_cfg.low_threshold + 1));
        endcase
    endfunction

    function automatic logic [15:0] pick_release();
        case ($urandom_range(3, 0))
            0:       return active_cfg.low_threshold;
            1:       return 16'h0000;
            default: return 16'($urandom_range(active_cfg.low_threshold, 0));
        endcase
    endfunction

    function automatic logic [15:0] pick_any();
        case ($urandom_range(3, 0))
            0:       return 16'h0000;
            1:       return FORCE_MAX;
            default: return 16'($urandom);
        endcase
    endfunction

    // Moves the millisecond clock on by a short, random, debounce-sized or hold-sized step.
    function automatic logic [TIME_W-1:0] next_stamp(input step_kind_t kind);
        logic [TIME_W-1:0] delta;
        case (kind)
            STEP_SHORT:
                delta = $urandom_range(3, 0);
            STEP_DEBOUNCE:
            begin
                delta = 32'(active_cfg.debounce_ms) + $urandom_range(2, 0);
                if (delta != 0)
                    delta = delta - 1;
            end
            STEP_HOLD:
            begin
                delta = 32'(active_cfg.hold_time_ms) + $urandom_range(2, 0);
                if (delta != 0)
                    delta = delta - 1;
            end
            default:
                delta = ($urandom_range(7, 0) == 0) ? $urandom : $urandom_range(60, 0);
        endcase
        stamp_ms = stamp_ms + delta;
        return stamp_ms;
    endfunction

    // Offers one item; the sender runs in bursts separated by random gaps.
    task automatic offer(input mode_t m, input logic [15:0] f, input logic [TIME_W-1:0] t);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(60, 20)
                                                      : $urandom_range(12, 1);
        end
        in_ch.valid        <= 1'b1;
        in_ch.mode         <= m;
        in_ch.force_sample <= f;
        in_ch.time_ms      <= t;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        burst_left--;
        items_sent++;
        if (m == MODE_SUPPRESS)
            suppress_sent++;
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] d);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
    endtask

    task automatic write_setting(input cfg_t c);
        write_reg(CFG_LOW_THRESHOLD, c.low_threshold);
        write_reg(CFG_HIGH_THRESHOLD, c.high_threshold);
        write_reg(CFG_ACTIVATION_OFFSET, c.activation_offset);
        write_reg(CFG_DEBOUNCE_MS, c.debounce_ms);
        // Only bit 0 of the curve register is meaningful.
        write_reg(CFG_CURVE_ENABLE, {15'($urandom), c.curve_enable});
        write_reg(CFG_HOLD_TIME_MS, c.hold_time_ms);
        write_reg(CFG_CHANGE_STEP, c.change_step);
        cfg_write <= 1'b0;
        @(posedge clk);
        active_cfg = c;
        settings_used++;
    endtask

    // Waits until every outstanding report has been transferred.
    task automatic settle();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    // One press from idle through to release, with random content.
    task automatic press_cycle();
        int unsigned n;
        n = $urandom_range(2, 0);
        repeat (n) offer(MODE_SAMPLE, pick_quiet(), next_stamp(STEP_ANY));
        offer(MODE_SAMPLE, pick_press(), next_stamp(STEP_ANY));
        if (active_cfg.debounce_ms != 0)
            repeat ($urandom_range(3, 1))
                offer(MODE_SAMPLE, pick_press(), next_stamp(STEP_DEBOUNCE));
        repeat ($urandom_range(7, 2))
        begin
            if ($urandom_range(9, 0) == 0)
                offer(MODE_SUPPRESS, 16'($urandom), $urandom);
            else
                offer(MODE_SAMPLE, pick_held(), next_stamp(step_kind_t'($urandom_range(3, 0))));
        end
        offer(MODE_SAMPLE, pick_release(), next_stamp(STEP_SHORT));
        if (active_cfg.debounce_ms != 0)
        begin
            if ($urandom_range(2, 0) == 0)
                offer(MODE_SAMPLE, pick_held(), next_stamp(STEP_SHORT));
            repeat ($urandom_range(3, 1))
                offer(MODE_SAMPLE, pick_release(), next_stamp(STEP_DEBOUNCE));
        end
    endtask

    task automatic run_phase(input cfg_t c, input int unsigned quota);
        int unsigned first;
        settle();
        write_setting(c);
        first = items_sent;
        while (items_sent - first < quota)
        begin
            if ($urandom_range(6, 0) == 0)
                offer(mode_t'($urandom_range(1, 0)), pick_any(), next_stamp(STEP_ANY));
            else
                press_cycle();
        end
    endtask

    // Receiver: stalls on patterns of its own, with one long hold-off so that
    // the block fills up and pushes back on its input.
    initial
    begin
        int unsigned style;
        int unsigned seg_len;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            // The hold-off starts early in a long phase so that the sender is
            // still offering items throughout it.
            if (!long_stall_done && items_sent >= 100)
            begin
                out_ch.ready <= 1'b0;
                repeat (300) @(posedge clk);
                long_stall_done = 1'b1;
            end
            style   = $urandom_range(3, 0);
            seg_len = $urandom_range(80, 10);
            for (int unsigned k = 0; k < seg_len; k++)
            begin
                case (style)
                    0:       out_ch.ready <= 1'b1;
                    1:       out_ch.ready <= ($urandom_range(99, 0) < 70);
                    2:       out_ch.ready <= ((k % 5) == 0);
                    default: out_ch.ready <= ($urandom_range(99, 0) < 25);
                endcase
                @(posedge clk);
            end
        end
    end

    initial
    begin
        int unsigned drain_wait;
        in_ch.valid        <= 1'b0;
        in_ch.mode         <= MODE_SAMPLE;
        in_ch.force_sample <= '0;
        in_ch.time_ms      <= '0;
        cfg_write          <= 1'b0;
        cfg_index          <= CFG_LOW_THRESHOLD;
        cfg_data           <= '0;
        rst_n              <= 1'b0;
        active_cfg      = make_cfg(16'd0, FORCE_MAX, 16'd0, 16'd0, 1'b0,
                                   HOLD_TIME_RST, CHANGE_STEP_RST);
        stamp_ms        = '0;
        items_sent      = 0;
        suppress_sent   = 0;
        burst_left      = 0;
        settings_used   = 0;
        long_stall_done = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register defaults: suppress before any sample, then a full press with
        // a muted hold and release, then a press and release at the lowest force.
        offer(MODE_SUPPRESS, FORCE_MAX, 32'hFFFF_FFFF);
        offer(MODE_SAMPLE, 16'h0000, 32'd0);
        offer(MODE_SAMPLE, FORCE_MAX, 32'd10);
        offer(MODE_SAMPLE, 16'h0100, 32'd20);
        offer(MODE_SUPPRESS, 16'h0000, 32'd0);
        offer(MODE_SAMPLE, 16'h8000, 32'd500);
        offer(MODE_SAMPLE, 16'h0000, 32'd501);
        offer(MODE_SAMPLE, 16'h0001, 32'd502);
        offer(MODE_SAMPLE, 16'h0000, 32'd503);

        // The press level is formed wide enough that full force cannot reach it.
        settle();
        write_setting(make_cfg(FORCE_MAX, FORCE_MAX, FORCE_MAX, 16'd0, 1'b0,
                               HOLD_TIME_RST, CHANGE_STEP_RST));
        offer(MODE_SAMPLE, FORCE_MAX, 32'd600);

        // Degenerate curve and both debounce paths, including a bounce back above
        // the low threshold during release debounce.
        settle();
        write_setting(make_cfg(16'd100, 16'd100, 16'd0, 16'd4, 1'b1, 16'd1000, 16'd0));
        offer(MODE_SAMPLE, 16'd101, 32'd1000);
        offer(MODE_SAMPLE, 16'd200, 32'd1002);
        offer(MODE_SAMPLE, 16'd200, 32'd1005);
        offer(MODE_SAMPLE, 16'd100, 32'd1006);
        offer(MODE_SAMPLE, 16'd150, 32'd1008);
        offer(MODE_SAMPLE, 16'd99, 32'd1009);
        offer(MODE_SAMPLE, 16'd150, 32'd1020);
        offer(MODE_SAMPLE, 16'd0, 32'd1021);
        offer(MODE_SAMPLE, 16'd50, 32'd1030);
        offer(MODE_SAMPLE, 16'd99, 32'd1031);

        // Dividing curve across a timestamp wrap; the step to the high threshold reaches full
        // scale with a change step that alone would not fire.
        settle();
        write_setting(make_cfg(16'd1000, 16'd3000, 16'd0, 16'd0, 1'b1, 16'd0, FORCE_MAX));
        offer(MODE_SAMPLE, 16'd2000, 32'hFFFF_FFF0);
        offer(MODE_SAMPLE, 16'd2999, 32'h0000_0005);
        offer(MODE_SAMPLE, 16'd3000, 32'h0000_0006);
        offer(MODE_SAMPLE, 16'd1000, 32'h0000_0007);
        stamp_ms = 32'h0000_0007;

        run_phase(make_cfg(16'd0, FORCE_MAX, 16'd0, 16'd0, 1'b0,
                           HOLD_TIME_RST, CHANGE_STEP_RST), 55);
        run_phase(make_cfg(16'd1000, 16'd50000, 16'd500, 16'd5, 1'b1, 16'd40, 16'd300), 55);
        run_phase(make_cfg(FORCE_MAX, 16'd0, FORCE_MAX, FORCE_MAX, 1'b1,
                           FORCE_MAX, FORCE_MAX), 40);
        run_phase(make_cfg(16'h8000, 16'h8001, 16'd0, 16'd1, 1'b1, 16'd0, 16'd0), 50);
        run_phase(make_cfg(16'd200, 16'd100, 16'd0, 16'd3, 1'b1, 16'd20, 16'd0), 50);
        run_phase(make_cfg(16'd0, FORCE_MAX, FORCE_MAX, FORCE_MAX, 1'b0,
                           FORCE_MAX, FORCE_MAX), 20);
        run_phase(random_cfg(), 55);
        run_phase(random_cfg(), 55);

        in_ch.valid <= 1'b0;
        drain_wait = 0;
        @(posedge clk);
        while (pending != 0 && drain_wait < 20000)
        begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (40) @(posedge clk);

        $display("Run covered %0d transfers in (%0d suppress) under %0d register settings.",
                 items_sent, suppress_sent, settings_used);
        $display("%0d reports checked, %0d key events, states reported %b, %0d left over.",
                 reports_checked, key_events, states_seen, pending);
        if (mismatches == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ppkt_pkg.sv
rtl/ppkt_if.sv
rtl/ppkt_front.sv
rtl/ppkt_queue.sv
rtl/ppkt_back.sv
rtl/pressure_pad_key_tracker.sv
tb/sv/ppkt_checker.sv
tb/sv/tb_top.sv
